FILE: rtl/hct_pkg.sv
// Package for the heater and cooler thermostat.
// Holds command codes, widths and reset constants shared by the RTL and the checker.
// No dependencies.
`timescale 1ns / 1ps

package hct_pkg;

  // Field widths
  localparam int CmdW      = 2;
  localparam int TempW     = 8;
  localparam int SpW       = 8;
  localparam int BlinkW    = 5;
  localparam int InUserW   = 2;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 16;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;

  // Command codes carried in the input tuser
  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_UP    = 2'd1;
  localparam logic [CmdW-1:0] CMD_DOWN  = 2'd2;
  localparam logic [CmdW-1:0] CMD_LEAVE = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SP_MIN = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SP_MAX = 1'b1;

  // Reset values and fixed constants
  localparam logic [SpW-1:0]    SETPOINT_INIT = 8'd60;
  localparam logic [SpW-1:0]    SP_MIN_RESET  = 8'd35;
  localparam logic [SpW-1:0]    SP_MAX_RESET  = 8'd75;
  localparam logic [BlinkW-1:0] BLINK_TICKS   = 5'd20;
  localparam logic [SpW-1:0]    BAND          = 8'd5;
  localparam logic [SpW-1:0]    STEP          = 8'd5;

  // Output word bit positions
  localparam int OutHeatBit = 0;
  localparam int OutCoolBit = 1;
  localparam int OutLedBit  = 2;
  localparam int OutSetBit  = 3;
  localparam int OutSpLsb   = 4;

endpackage

FILE: rtl/heater_cooler_thermostat_unit.sv
// Heater and cooler thermostat, top level: decision logic and result register.
// Depends on hct_pkg.
`timescale 1ns / 1ps

// Every accepted word yields exactly one result word in the next cycle. A control
// tick compares the temperature against setpoint +/- 5 with hysteresis and
// drives heater or cooler; while heating, the heat LED toggles every 20
// ticks. A button press in normal mode enters set mode (both drives off);
// in set mode up/down move the setpoint by 5 while it is below setpoint_max
// (up) or above setpoint_min (down); a leave command returns to normal mode.
// One word is taken per clock: the whole update is a single compare-and-select
// stage between the input handshake and the result register, and a new word is
// taken whenever the result register is empty or being drained.
module heater_cooler_thermostat_unit
  import hct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input words: tuser [1:0] cmd; tdata [7:0] water temperature
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InUserW-1:0]  s_axis_tuser,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Result words: [0] heater_on, [1] cooler_on, [2] heat_led,
  // [3] in_set_mode, [11:4] setpoint_out, [15:12] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic [SpW-1:0] setpoint_min;
  logic [SpW-1:0] setpoint_max;

  // Controller state
  logic              set_mode, set_mode_next;
  logic              heating_active, heating_active_next;
  logic              cooling_active, cooling_active_next;
  logic [BlinkW-1:0] blink_count, blink_count_next;
  logic              led_level, led_level_next;
  logic [SpW-1:0]    setpoint, setpoint_next;

  // Result register
  logic                out_valid;
  logic [OutDataW-1:0] out_data;

  logic             in_accept;
  logic [CmdW-1:0]  cmd;
  logic [TempW-1:0] water_temp;

  // Comparison terms on 9 bits so that setpoint +/- 5 never wraps
  logic [SpW:0] t_ext, s_ext, t_plus_band, s_plus_band;
  logic         t_below_lo, t_below_hi, t_above_hi, t_above_lo;
  logic         heat, cool;
  logic [BlinkW-1:0] blink_inc;

  assign cmd        = s_axis_tuser[CmdW-1:0];
  assign water_temp = s_axis_tdata[TempW-1:0];

  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign t_ext       = {1'b0, water_temp};
  assign s_ext       = {1'b0, setpoint};
  assign t_plus_band = t_ext + {1'b0, BAND};
  assign s_plus_band = s_ext + {1'b0, BAND};

  // t < s-5, t < s+5, t > s+5, t > s-5
  assign t_below_lo = t_plus_band < s_ext;
  assign t_below_hi = t_ext < s_plus_band;
  assign t_above_hi = t_ext > s_plus_band;
  assign t_above_lo = t_plus_band > s_ext;

  assign heat      = t_below_lo || (t_below_hi && heating_active);
  assign cool      = !heat && (t_above_hi || (t_above_lo && cooling_active));
  assign blink_inc = blink_count + 5'd1;

  // Next-state logic for one command
  always_comb begin
    set_mode_next       = set_mode;
    heating_active_next = heating_active;
    cooling_active_next = cooling_active;
    blink_count_next    = blink_count;
    led_level_next      = led_level;
    setpoint_next       = setpoint;
    case (cmd)
      CMD_TICK: begin
        if (set_mode) begin
          heating_active_next = 1'b0;
          cooling_active_next = 1'b0;
        end else if (heat) begin
          heating_active_next = 1'b1;
          cooling_active_next = 1'b0;
          if (blink_inc == BLINK_TICKS) begin
            blink_count_next = '0;
            led_level_next   = !led_level;
          end else begin
            blink_count_next = blink_inc;
          end
        end else if (cool) begin
          heating_active_next = 1'b0;
          cooling_active_next = 1'b1;
          blink_count_next    = '0;
          led_level_next      = 1'b1;
        end else begin
          heating_active_next = 1'b0;
          cooling_active_next = 1'b0;
          blink_count_next    = '0;
          led_level_next      = 1'b0;
        end
      end
      CMD_UP, CMD_DOWN: begin
        if (!set_mode) begin
          set_mode_next       = 1'b1;
          heating_active_next = 1'b0;
          cooling_active_next = 1'b0;
        end else if (cmd == CMD_UP) begin
          // Increase, saturating at 255
          if (setpoint < setpoint_max) begin
            setpoint_next = (setpoint > (8'd255 - STEP)) ? 8'd255 : setpoint + STEP;
          end
        end else begin
          // Decrease, saturating at zero
          if (setpoint > setpoint_min) begin
            setpoint_next = (setpoint < STEP) ? 8'd0 : setpoint - STEP;
          end
        end
      end
      CMD_LEAVE: begin
        set_mode_next = 1'b0;
      end
      default: begin
        set_mode_next = set_mode;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_min <= SP_MIN_RESET;
      setpoint_max <= SP_MAX_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SP_MIN) begin
        setpoint_min <= cfg_data;
      end else begin
        setpoint_max <= cfg_data;
      end
    end
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      set_mode       <= 1'b0;
      heating_active <= 1'b0;
      cooling_active <= 1'b0;
      blink_count    <= '0;
      led_level      <= 1'b0;
      setpoint       <= SETPOINT_INIT;
    end else if (in_accept) begin
      set_mode       <= set_mode_next;
      heating_active <= heating_active_next;
      cooling_active <= cooling_active_next;
      blink_count    <= blink_count_next;
      led_level      <= led_level_next;
      setpoint       <= setpoint_next;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: the state after this word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= {{(OutDataW-OutSpLsb-SpW){1'b0}}, setpoint_next, set_mode_next,
                   led_level_next, cooling_active_next, heating_active_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: rtl/hct_checker.sv
// Port-level checker for the heater and cooler thermostat, bound to the top level.
// Depends on hct_pkg and heater_cooler_thermostat_unit.
`timescale 1ns / 1ps

module hct_checker
  import hct_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InUserW-1:0]  s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic in_accept;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Heater and cooler are never driven together.
  a_no_both_drives: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[OutHeatBit] && m_axis_tdata[OutCoolBit]))
    else $error("heater and cooler both on");

  // Both drives are off throughout set mode.
  a_set_mode_drives_off: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[OutSetBit])
      |-> (!m_axis_tdata[OutHeatBit] && !m_axis_tdata[OutCoolBit]))
    else $error("drive on in set mode");

  // A leave command always yields a normal-mode word in the next cycle.
  a_leave_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser[CmdW-1:0] == CMD_LEAVE)
      |=> (m_axis_tvalid && !m_axis_tdata[OutSetBit]))
    else $error("leave did not return to normal mode");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind heater_cooler_thermostat_unit hct_checker u_hct_checker (.*);
